// ----- rtl/egcd_pkg.sv -----
// Shared constants, types and state codes for the extended gcd block.
package egcd_pkg;

  // Default operand width
  localparam int EGCD_DATA_WIDTH = 32;

  // Per-cycle status from the serial divider
  typedef struct packed {
    logic step;   // a quotient bit is produced this cycle
    logic qbit;   // the quotient bit, MSB first
    logic done;   // remainder is final, one-cycle pulse
  } div_stat_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOP = 5'b00010,
    S_DIV  = 5'b00100,
    S_MOD  = 5'b01000,
    S_FIX  = 5'b10000
  } state_t;

endpackage

// ----- rtl/egcd_if.sv -----
// Valid/ready channel interfaces for operand words and result words.
interface egcd_in_if #(parameter int DW = egcd_pkg::EGCD_DATA_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] first_operand;
  logic signed [DW-1:0] second_operand;

  modport source(output valid, output first_operand, output second_operand, input ready);
  modport sink(input valid, input first_operand, input second_operand, output ready);
endinterface

interface egcd_out_if #(parameter int DW = egcd_pkg::EGCD_DATA_WIDTH);
  logic                 valid;
  logic                 ready;
  logic        [DW-2:0] gcd_value;
  logic signed [DW-1:0] coef_first;
  logic signed [DW-1:0] coef_second;
  logic signed [DW-1:0] inverse_value;
  logic                 has_inverse;

  modport source(output valid, output gcd_value, output coef_first, output coef_second,
                 output inverse_value, output has_inverse, input ready);
  modport sink(input valid, input gcd_value, input coef_first, input coef_second,
               input inverse_value, input has_inverse, output ready);
endinterface

// ----- rtl/egcd_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module egcd_div #(
  parameter int MW = egcd_pkg::EGCD_DATA_WIDTH - 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MW-1:0]     num,
  input  logic [MW-1:0]     den,
  output egcd_pkg::div_stat_t stat,
  output logic [MW-1:0]     rem
);
  import egcd_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] num_r, num_nxt;
  logic [MW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [MW:0]   shifted;
  logic [MW:0]   diff;
  logic          ge;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem_r, num_r[MW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = CW'(MW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[MW-1:0] : shifted[MW-1:0];
      num_nxt = {num_r[MW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign stat.step = busy_r;
  assign stat.qbit = ge;
  assign stat.done = done_r;
  assign rem       = rem_r;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without a finished pass");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> den != '0)
    else $error("divider started with zero divisor");

endmodule

// ----- rtl/extended_gcd_modular_inverse.sv -----
// Top level: extended Euclid sequencer, continuants, sign fix-up and result register.
// Takes two signed operands and returns gcd(|a|,|b|), Bezout coefficients x, y with
// a*x + b*y = g, and the inverse of a modulo b (flagged) when g is 1 and b > 0; the
// most negative operand is treated as one above it. All work goes through a single
// bit-serial divider: each Euclid step is one divider pass yielding DATA_WIDTH-1 quotient
// bits, and the final reduction for the inverse is one more such pass, with setup and
// hand-off states around them. At DATA_WIDTH = 32 the worst case is 45 steps; in_ready
// is high only while idle, and a new word is taken while the previous result still
// waits on the output.
module extended_gcd_modular_inverse #(
  parameter int DATA_WIDTH = egcd_pkg::EGCD_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  egcd_in_if.sink    in_if,
  egcd_out_if.source out_if
);
  import egcd_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int MW = DATA_WIDTH - 1;

  state_t        state_r, state_nxt;
  logic [MW-1:0] ra_r, ra_nxt;
  logic [MW-1:0] rb_r, rb_nxt;
  logic [MW-1:0] pc_r, pc_nxt;
  logic [MW-1:0] pp_r, pp_nxt;
  logic [MW-1:0] qc_r, qc_nxt;
  logic [MW-1:0] qp_r, qp_nxt;
  logic [MW-1:0] tp_r, tp_nxt;
  logic [MW-1:0] tq_r, tq_nxt;
  logic [MW-1:0] bmag_r, bmag_nxt;
  logic [MW-1:0] inv_r, inv_nxt;
  logic          odd_r, odd_nxt;
  logic          na_r, na_nxt;
  logic          nb_r, nb_nxt;
  logic          bpos_r, bpos_nxt;
  logic          flag_r, flag_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [MW-1:0] out_gcd_r, out_gcd_nxt;
  logic [DW-1:0] out_cf_r, out_cf_nxt;
  logic [DW-1:0] out_cs_r, out_cs_nxt;
  logic [DW-1:0] out_inv_r, out_inv_nxt;
  logic          out_flag_r, out_flag_nxt;

  logic [DW-1:0] a_raw, b_raw, a_neg, b_neg;
  logic [MW-1:0] a_mag, b_mag;
  logic          in_take, out_load;
  logic          xneg, yneg;
  logic [DW-1:0] qp_ext, pp_ext;

  logic          div_start;
  logic [MW-1:0] div_num, div_den, div_rem;
  div_stat_t     div_stat;

  // Operand magnitudes, most negative pattern saturated
  assign a_raw = in_if.first_operand;
  assign b_raw = in_if.second_operand;
  assign a_neg = ~a_raw + DW'(1);
  assign b_neg = ~b_raw + DW'(1);
  assign a_mag = !a_raw[DW-1] ? a_raw[MW-1:0] :
                 (a_neg[DW-1] ? {MW{1'b1}} : a_neg[MW-1:0]);
  assign b_mag = !b_raw[DW-1] ? b_raw[MW-1:0] :
                 (b_neg[DW-1] ? {MW{1'b1}} : b_neg[MW-1:0]);

  assign in_take  = in_if.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_FIX) && (!out_valid_r || out_if.ready);

  // Coefficient signs from step parity and operand signs
  assign xneg   = (na_r != odd_r) && (qp_r != '0);
  assign yneg   = (nb_r == odd_r) && (pp_r != '0);
  assign qp_ext = {1'b0, qp_r};
  assign pp_ext = {1'b0, pp_r};

  // Divider operands: Euclid step or final reduction of x modulo b
  assign div_start = (state_r == S_LOOP) && ((rb_r != '0) || (ra_r == MW'(1) && bpos_r));
  assign div_num   = (rb_r != '0) ? ra_r : qp_r;
  assign div_den   = (rb_r != '0) ? rb_r : bmag_r;

  egcd_div #(.MW(MW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .rem   (div_rem)
  );

  // Sequencer and continuant datapath
  always_comb begin
    state_nxt     = state_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    pc_nxt        = pc_r;
    pp_nxt        = pp_r;
    qc_nxt        = qc_r;
    qp_nxt        = qp_r;
    tp_nxt        = tp_r;
    tq_nxt        = tq_r;
    bmag_nxt      = bmag_r;
    inv_nxt       = inv_r;
    odd_nxt       = odd_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    bpos_nxt      = bpos_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_gcd_nxt   = out_gcd_r;
    out_cf_nxt    = out_cf_r;
    out_cs_nxt    = out_cs_r;
    out_inv_nxt   = out_inv_r;
    out_flag_nxt  = out_flag_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          ra_nxt    = a_mag;
          rb_nxt    = b_mag;
          bmag_nxt  = b_mag;
          na_nxt    = a_raw[DW-1];
          nb_nxt    = b_raw[DW-1];
          bpos_nxt  = !b_raw[DW-1] && (b_raw != '0);
          pc_nxt    = MW'(1);
          pp_nxt    = '0;
          qc_nxt    = '0;
          qp_nxt    = MW'(1);
          odd_nxt   = 1'b0;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        tp_nxt = '0;
        tq_nxt = '0;
        if (rb_r != '0) begin
          state_nxt = S_DIV;
        end else begin
          flag_nxt  = (ra_r == MW'(1)) && bpos_r;
          state_nxt = div_start ? S_MOD : S_FIX;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          // next continuants: cur*q + prev
          ra_nxt    = rb_r;
          rb_nxt    = div_rem;
          pc_nxt    = tp_r + pp_r;
          pp_nxt    = pc_r;
          qc_nxt    = tq_r + qp_r;
          qp_nxt    = qc_r;
          odd_nxt   = !odd_r;
          state_nxt = S_LOOP;
        end else if (div_stat.step) begin
          // Horner accumulation of cur*q, one quotient bit a cycle
          tp_nxt = {tp_r[MW-2:0], 1'b0} + (div_stat.qbit ? pc_r : '0);
          tq_nxt = {tq_r[MW-2:0], 1'b0} + (div_stat.qbit ? qc_r : '0);
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          inv_nxt   = (xneg && div_rem != '0) ? (bmag_r - div_rem) : div_rem;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_gcd_nxt   = ra_r;
          out_cf_nxt    = xneg ? (~qp_ext + DW'(1)) : qp_ext;
          out_cs_nxt    = yneg ? (~pp_ext + DW'(1)) : pp_ext;
          out_inv_nxt   = flag_r ? {1'b0, inv_r} : {DW{1'b1}};
          out_flag_nxt  = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result word
  always_ff @(posedge clk) begin
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    pc_r       <= pc_nxt;
    pp_r       <= pp_nxt;
    qc_r       <= qc_nxt;
    qp_r       <= qp_nxt;
    tp_r       <= tp_nxt;
    tq_r       <= tq_nxt;
    bmag_r     <= bmag_nxt;
    inv_r      <= inv_nxt;
    odd_r      <= odd_nxt;
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    bpos_r     <= bpos_nxt;
    flag_r     <= flag_nxt;
    out_gcd_r  <= out_gcd_nxt;
    out_cf_r   <= out_cf_nxt;
    out_cs_r   <= out_cs_nxt;
    out_inv_r  <= out_inv_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_if.ready          = (state_r == S_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.gcd_value     = out_gcd_r;
  assign out_if.coef_first    = out_cf_r;
  assign out_if.coef_second   = out_cs_r;
  assign out_if.inverse_value = out_inv_r;
  assign out_if.has_inverse   = out_flag_r;

  // Checks
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV || state_r == S_MOD))
    else $error("divider finished outside a division state");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result word lost on load");
  a_flag_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flag_r) |-> (out_gcd_r == MW'(1)))
    else $error("inverse flagged with gcd other than one");
  a_noflag_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_flag_r) |-> (out_inv_r == {DW{1'b1}}))
    else $error("missing inverse not reported as minus one");

endmodule
